FILE: design/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and constants of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam int BYTE_W     = 8;
	localparam int LINE_CNT_W = 6;
	localparam int SLACK_W    = 8;
	localparam int MAX_LEN_W  = 32;
	localparam int EXCESS_W   = SLACK_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [LINE_CNT_W-1:0] MAX_LINE_RST = 6'd16;
	localparam logic [SLACK_W-1:0]    SLACK_RST    = 8'd20;
	localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RST  = 32'hffff_ffff;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLACK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 2'd2;

	typedef enum logic [2:0] {
		PH_LINE     = 3'd0,
		PH_OPEN_CR  = 3'd1,
		PH_DATA     = 3'd2,
		PH_CLOSE_CR = 3'd3,
		PH_DONE     = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD    = 2'd0,
		EV_CHUNK_DONE = 2'd1,
		EV_BODY_DONE  = 2'd2,
		EV_ERROR      = 2'd3
	} event_kind_t;

	typedef enum logic [2:0] {
		ERR_FIRST_NOT_DIGIT = 3'd0,
		ERR_LINE_TOO_LONG   = 3'd1,
		ERR_BAD_HEX         = 3'd2,
		ERR_CLOSE_LATE      = 3'd3,
		ERR_TOO_BIG         = 3'd4
	} err_code_t;

	// code carried by events other than errors
	localparam err_code_t ERR_NONE = ERR_FIRST_NOT_DIGIT;

	typedef struct packed {
		event_kind_t        kind;
		logic [BYTE_W-1:0]  payload;
		err_code_t          code;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			h.value = 4'(c - 8'h30);
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			h.value = 4'(c - 8'h57);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: design/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-wide decoder for an HTTP body in chunked transfer coding
// ----------------------------------------------------------------------------
// Input stream: one body byte per transaction in s_axis_tdata, s_axis_tuser
// high on the first byte of a new message (clears the parser), s_axis_tlast
// marks the end of a receive block and does not affect parsing.
// Output stream: at most one event per input byte; m_axis_tuser holds the
// event kind (payload byte, chunk complete, body complete, error),
// m_axis_tdata the payload byte and the error code.
// Configuration channel: cfg_index selects max line chars (0), close slack
// (1) or max chunk length (2); it is always ready; the user must write it
// only while idle, which the block itself does not enforce. Throughput:
// one byte per cycle while the skid register is empty; the per-byte
// parser update is a compare and a 4-bit shift-accumulate on the chunk
// length register. Stall: a two-entry output buffer (result register and
// skid register) lets one more event in while the receiver stalls;
// s_axis_tready drops once the skid register holds an event.
// Reset: parser at the start of a length line, registers at 16, 20 and
// all ones, output buffer empty.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
	parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [hcbd_pkg::BYTE_W-1:0]        s_axis_tdata,  // data_byte
	input  logic                               s_axis_tuser,  // msg_start
	input  logic                               s_axis_tlast,  // block_last
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [15:0]                        m_axis_tdata,  // payload_byte, error_code, zero pad
	output logic [1:0]                         m_axis_tuser,  // event_kind
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hcbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CMP_W = (LENGTH_BITS > hcbd_pkg::MAX_LEN_W) ? LENGTH_BITS
		: hcbd_pkg::MAX_LEN_W;

	logic [hcbd_pkg::LINE_CNT_W-1:0] max_line_q;
	logic [hcbd_pkg::SLACK_W-1:0]    slack_q;
	logic [hcbd_pkg::MAX_LEN_W-1:0]  max_chunk_q;

	hcbd_pkg::phase_t                 phase_q, phase_n, phase_c;
	logic [LENGTH_BITS-1:0]           len_q, len_n, len_c;
	logic [LENGTH_BITS-1:0]           rem_q, rem_n;
	logic [hcbd_pkg::LINE_CNT_W-1:0]  cnt_q, cnt_n, cnt_c;
	logic [hcbd_pkg::EXCESS_W-1:0]    exc_q, exc_n, exc_inc;
	logic                             bad_q, bad_n, bad_c;

	hcbd_pkg::result_t  res, out_q, skid_q;
	logic               res_v, out_valid_q, skid_valid_q;
	logic               in_acc, push, pop;
	logic [hcbd_pkg::BYTE_W-1:0] c;
	hcbd_pkg::hex_t     hex;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign push          = in_acc && res_v;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign c             = s_axis_tdata;
	assign hex           = hcbd_pkg::hex_decode(c);
	assign exc_inc       = exc_q + 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {5'd0, out_q.code, out_q.payload};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q  <= hcbd_pkg::MAX_LINE_RST;
			slack_q     <= hcbd_pkg::SLACK_RST;
			max_chunk_q <= hcbd_pkg::MAX_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hcbd_pkg::CFG_MAX_LINE:  max_line_q  <= cfg_data[hcbd_pkg::LINE_CNT_W-1:0];
				hcbd_pkg::CFG_SLACK:     slack_q     <= cfg_data[hcbd_pkg::SLACK_W-1:0];
				hcbd_pkg::CFG_MAX_CHUNK: max_chunk_q <= cfg_data[hcbd_pkg::MAX_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// message start clears the parser before the byte is parsed
	always_comb begin
		if (s_axis_tuser) begin
			phase_c = hcbd_pkg::PH_LINE;
			len_c   = '0;
			cnt_c   = '0;
			bad_c   = 1'b0;
		end else begin
			phase_c = phase_q;
			len_c   = len_q;
			cnt_c   = cnt_q;
			bad_c   = bad_q;
		end
	end

	// next parser state and event
	always_comb begin
		phase_n     = phase_c;
		len_n       = len_c;
		cnt_n       = cnt_c;
		bad_n       = bad_c;
		rem_n       = rem_q;
		exc_n       = exc_q;
		res_v       = 1'b0;
		res.kind    = hcbd_pkg::EV_PAYLOAD;
		res.payload = '0;
		res.code    = hcbd_pkg::ERR_NONE;
		unique case (phase_c)
			hcbd_pkg::PH_LINE: begin
				if ((cnt_c == '0) && !hcbd_pkg::is_digit(c)) begin
					phase_n  = hcbd_pkg::PH_ERROR;
					res_v    = 1'b1;
					res.kind = hcbd_pkg::EV_ERROR;
					res.code = hcbd_pkg::ERR_FIRST_NOT_DIGIT;
				end else if (c == hcbd_pkg::CH_CR) begin
					if (bad_c) begin
						phase_n  = hcbd_pkg::PH_ERROR;
						res_v    = 1'b1;
						res.kind = hcbd_pkg::EV_ERROR;
						res.code = hcbd_pkg::ERR_BAD_HEX;
					end else if (CMP_W'(len_c) > CMP_W'(max_chunk_q)) begin
						phase_n  = hcbd_pkg::PH_ERROR;
						res_v    = 1'b1;
						res.kind = hcbd_pkg::EV_ERROR;
						res.code = hcbd_pkg::ERR_TOO_BIG;
					end else begin
						phase_n = hcbd_pkg::PH_OPEN_CR;
					end
				end else if (cnt_c >= max_line_q) begin
					phase_n  = hcbd_pkg::PH_ERROR;
					res_v    = 1'b1;
					res.kind = hcbd_pkg::EV_ERROR;
					res.code = hcbd_pkg::ERR_LINE_TOO_LONG;
				end else begin
					cnt_n = cnt_c + 1'b1;
					if (!bad_c) begin
						if (!hex.valid) begin
							bad_n = 1'b1;
						end else if (len_c[LENGTH_BITS-1 -: 4] != 4'd0) begin
							phase_n  = hcbd_pkg::PH_ERROR;
							res_v    = 1'b1;
							res.kind = hcbd_pkg::EV_ERROR;
							res.code = hcbd_pkg::ERR_TOO_BIG;
						end else begin
							len_n = {len_c[LENGTH_BITS-5:0], hex.value};
						end
					end
				end
			end
			hcbd_pkg::PH_OPEN_CR: begin
				if (c == hcbd_pkg::CH_LF) begin
					phase_n = hcbd_pkg::PH_DATA;
					rem_n   = len_c;
					exc_n   = '0;
				end
			end
			hcbd_pkg::PH_DATA: begin
				if (rem_q != '0) begin
					rem_n       = rem_q - 1'b1;
					res_v       = 1'b1;
					res.kind    = hcbd_pkg::EV_PAYLOAD;
					res.payload = c;
				end else if (exc_q > hcbd_pkg::EXCESS_W'(slack_q)) begin
					phase_n  = hcbd_pkg::PH_ERROR;
					res_v    = 1'b1;
					res.kind = hcbd_pkg::EV_ERROR;
					res.code = hcbd_pkg::ERR_CLOSE_LATE;
				end else if (c == hcbd_pkg::CH_CR) begin
					phase_n = hcbd_pkg::PH_CLOSE_CR;
				end else begin
					exc_n = exc_inc;
					if (exc_inc > hcbd_pkg::EXCESS_W'(slack_q)) begin
						phase_n  = hcbd_pkg::PH_ERROR;
						res_v    = 1'b1;
						res.kind = hcbd_pkg::EV_ERROR;
						res.code = hcbd_pkg::ERR_CLOSE_LATE;
					end
				end
			end
			hcbd_pkg::PH_CLOSE_CR: begin
				if (c == hcbd_pkg::CH_LF) begin
					res_v = 1'b1;
					if (len_c == '0) begin
						phase_n  = hcbd_pkg::PH_DONE;
						res.kind = hcbd_pkg::EV_BODY_DONE;
					end else begin
						phase_n  = hcbd_pkg::PH_LINE;
						len_n    = '0;
						cnt_n    = '0;
						bad_n    = 1'b0;
						res.kind = hcbd_pkg::EV_CHUNK_DONE;
					end
				end
			end
			default: ;
		endcase
	end

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_LINE;
			len_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			exc_q   <= '0;
			bad_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			rem_q   <= rem_n;
			cnt_q   <= cnt_n;
			exc_q   <= exc_n;
			bad_q   <= bad_n;
		end
	end

	// output buffer: result register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an event while the result register is empty");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind != hcbd_pkg::EV_PAYLOAD)) |-> (out_q.payload == '0))
		else $error("non-payload event carries a data byte");

	a_locked_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_axis_tuser &&
		((phase_q == hcbd_pkg::PH_DONE) || (phase_q == hcbd_pkg::PH_ERROR))) |-> !res_v)
		else $error("event produced while the parser is locked");

	a_error_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (res.kind == hcbd_pkg::EV_ERROR)) |=> (phase_q == hcbd_pkg::PH_ERROR))
		else $error("error event without entering the error lock");

endmodule

FILE: tb/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking testbench of the chunked body decoder
// ----------------------------------------------------------------------------
// A clocked driver feeds body bytes from a queue and a clocked monitor
// predicts the event of every accepted byte with a byte-level parser model.
// Each output event is checked field by field in order. Stimulus starts with
// hand-built bodies for the error and corner cases and continues with random
// bodies, damaged bodies and noise under several register settings, with
// random idle cycles on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int LEN_W       = LENGTH_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
		logic              last;
	} in_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;  // payload_byte, error_code, zero pad
	logic [1:0]            m_axis_tuser;  // event_kind
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// parser model state and register copies
	phase_t              ph = PH_LINE;
	logic [LEN_W-1:0]    chunk_len = '0;
	logic [LINE_CNT_W-1:0] line_cnt = '0;
	logic [LEN_W:0]      data_off = '0;
	logic                line_bad = 1'b0;
	logic [LINE_CNT_W-1:0] max_line = MAX_LINE_RST;
	logic [SLACK_W-1:0]  slack = SLACK_RST;
	logic [MAX_LEN_W-1:0] max_chunk = MAX_LEN_RST;

	in_item_t byte_q[$];
	in_item_t stage_q[$];
	result_t  event_q[$];
	int       queued = 0;
	int       errors = 0;
	int       cycles = 0;
	bit       byte_taken = 1'b0;
	bit       calm = 1'b0;
	int       stall_req = 0;
	int       stall_seen = 0;
	int       stall_left = 0;

	http_chunked_body_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void note_event(input event_kind_t k, input logic [BYTE_W-1:0] b,
			input err_code_t e);
		result_t r;
		r.kind = k;
		r.payload = b;
		r.code = e;
		event_q.push_back(r);
	endfunction

	function automatic void raise_error(input err_code_t e);
		ph = PH_ERROR;
		note_event(EV_ERROR, 8'h00, e);
	endfunction

	function automatic void clear_parser();
		ph = PH_LINE;
		chunk_len = '0;
		line_cnt = '0;
		data_off = '0;
		line_bad = 1'b0;
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] c, input logic start);
		int hv;
		if (start)
			clear_parser();
		case (ph)
			PH_LINE: begin
				if (line_cnt == 0 && !(c >= "0" && c <= "9")) begin
					raise_error(ERR_FIRST_NOT_DIGIT);
					return;
				end
				if (c == CH_CR) begin
					if (line_bad)
						raise_error(ERR_BAD_HEX);
					else if (chunk_len > max_chunk)
						raise_error(ERR_TOO_BIG);
					else
						ph = PH_OPEN_CR;
					return;
				end
				if (line_cnt >= max_line) begin
					raise_error(ERR_LINE_TOO_LONG);
					return;
				end
				line_cnt++;
				if (!line_bad) begin
					if (c >= "0" && c <= "9")
						hv = c - "0";
					else if (c >= "a" && c <= "f")
						hv = c - "a" + 10;
					else if (c >= "A" && c <= "F")
						hv = c - "A" + 10;
					else
						hv = -1;
					if (hv < 0) begin
						line_bad = 1'b1;
					end else if (chunk_len[LEN_W-1 -: 4] != 0) begin
						raise_error(ERR_TOO_BIG);
					end else begin
						chunk_len = {chunk_len[LEN_W-5:0], 4'(hv)};
					end
				end
			end
			PH_OPEN_CR: begin
				if (c == CH_LF) begin
					ph = PH_DATA;
					data_off = '0;
				end
			end
			PH_DATA: begin
				if (data_off < (LEN_W+1)'(chunk_len)) begin
					data_off++;
					note_event(EV_PAYLOAD, c, ERR_NONE);
				end else if (data_off - (LEN_W+1)'(chunk_len) > (LEN_W+1)'(slack)) begin
					raise_error(ERR_CLOSE_LATE);
				end else if (c == CH_CR) begin
					ph = PH_CLOSE_CR;
				end else begin
					data_off++;
					if (data_off - (LEN_W+1)'(chunk_len) > (LEN_W+1)'(slack))
						raise_error(ERR_CLOSE_LATE);
				end
			end
			PH_CLOSE_CR: begin
				if (c == CH_LF) begin
					if (chunk_len == 0) begin
						ph = PH_DONE;
						note_event(EV_BODY_DONE, 8'h00, ERR_NONE);
					end else begin
						clear_parser();
						note_event(EV_CHUNK_DONE, 8'h00, ERR_NONE);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// sampling, prediction and checking
	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			byte_taken = s_axis_tvalid && s_axis_tready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_LINE:  max_line = cfg_data[LINE_CNT_W-1:0];
					CFG_SLACK:     slack = cfg_data[SLACK_W-1:0];
					CFG_MAX_CHUNK: max_chunk = cfg_data[MAX_LEN_W-1:0];
					default: ;
				endcase
			end
			if (byte_taken)
				decode_byte(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				if (event_q.size() == 0) begin
					$error("unexpected event: event_kind %0d payload_byte %0h error_code %0d",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8]);
					errors++;
				end else begin
					want = event_q.pop_front();
					if (want.kind !== m_axis_tuser) begin
						$error("event_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
						errors++;
					end
					if (want.payload !== m_axis_tdata[7:0]) begin
						$error("payload_byte: expected %0h, actual %0h", want.payload,
							m_axis_tdata[7:0]);
						errors++;
					end
					if (want.code !== m_axis_tdata[10:8]) begin
						$error("error_code: expected %0d, actual %0d", want.code,
							m_axis_tdata[10:8]);
						errors++;
					end
				end
			end
		end
	end

	// byte sender
	always @(negedge clk) begin
		in_item_t next_item;
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
				next_item = byte_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_item.data;
				s_axis_tuser <= next_item.start;
				s_axis_tlast <= next_item.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// event receiver
	always @(negedge clk) begin
		if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			stall_left = 120;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || $urandom_range(0, 99) >= 9;
		end
	end

	function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] avoid);
		logic [BYTE_W-1:0] b;
		b = $urandom_range(0, 255);
		if (b == avoid)
			b = ~b;
		return b;
	endfunction

	task automatic put(input logic [BYTE_W-1:0] b, input logic start = 1'b0);
		in_item_t it;
		it.data = b;
		it.start = start;
		it.last = $urandom_range(0, 7) == 0;
		stage_q.push_back(it);
	endtask

	task automatic put_text(input string s, input logic start);
		for (int i = 0; i < s.len(); i++)
			put(s[i], start && i == 0);
	endtask

	task automatic commit_stage(input bit mangle);
		int pos;
		if (mangle && stage_q.size() > 1) begin
			pos = $urandom_range(1, stage_q.size() - 1);
			stage_q[pos].data = $urandom_range(0, 255);
			stage_q[pos].start = $urandom_range(0, 3) == 0;
			if ($urandom_range(0, 1))
				stage_q = stage_q[0:pos];
		end
		foreach (stage_q[i])
			byte_q.push_back(stage_q[i]);
		queued += stage_q.size();
		stage_q.delete();
	endtask

	task automatic add_chunk(input int unsigned len, input bit first);
		string digits;
		int pad;
		int extra;
		digits = $sformatf("%0h", len);
		if ($urandom_range(0, 1))
			digits = digits.toupper();
		// a length line must open with a decimal digit
		pad = (digits[0] > "9") ? 1 : 0;
		if (digits.len() + pad < max_line && $urandom_range(0, 3) == 0)
			pad++;
		repeat (pad) digits = {"0", digits};
		put_text(digits, first);
		put(CH_CR);
		if ($urandom_range(0, 7) == 0)
			put(other_than(CH_LF));
		put(CH_LF);
		repeat (len) put($urandom_range(0, 255));
		extra = $urandom_range(0, (slack < 3) ? slack : 3);
		repeat (extra) put(other_than(CH_CR));
		put(CH_CR);
		if ($urandom_range(0, 7) == 0)
			put(other_than(CH_LF));
		put(CH_LF);
	endtask

	task automatic add_body(input int max_bytes);
		int n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			add_chunk($urandom_range(1, max_bytes), i == 0);
		add_chunk(0, n == 0);
	endtask

	task automatic add_traffic(input int n_items, input int max_bytes);
		int goal;
		goal = queued + n_items;
		while (queued < goal) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 6))
						put($urandom_range(0, 255), $urandom_range(0, 3) == 0);
					commit_stage(1'b0);
				end
				1, 2: begin
					add_body(max_bytes);
					commit_stage(1'b1);
				end
				default: begin
					add_body(max_bytes);
					commit_stage(1'b0);
				end
			endcase
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (byte_q.size() != 0 || s_axis_tvalid || event_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: first-character errors, bad hex, overflow, full body
		put_text("g", 1'b1);
		put(CH_CR, 1'b1);
		put_text("1z", 1'b1);
		put(CH_CR);
		put_text("100000000", 1'b1);
		put_text("2", 1'b1);
		put(CH_CR);
		put("x");
		put(CH_LF);
		put(8'hff);
		put(8'h00);
		put("x");
		put(CH_CR);
		put(CH_LF);
		put_text("0", 1'b0);
		put(CH_CR);
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		put("5");
		commit_stage(1'b0);
		add_traffic(30, 16);
		stall_req++;
		drain();

		write_reg(CFG_MAX_LINE, 32'd1);
		write_reg(CFG_SLACK, 32'd0);
		write_reg(CFG_MAX_CHUNK, 32'd5);
		put_text("12", 1'b1);
		put_text("1", 1'b1);
		put(CH_CR);
		put(CH_LF);
		put(8'h41);
		put("y");
		put_text("7", 1'b1);
		put(CH_CR);
		commit_stage(1'b0);
		add_traffic(15, 9);
		drain();

		write_reg(CFG_MAX_LINE, 32'd63);
		write_reg(CFG_SLACK, 32'd60);
		write_reg(CFG_MAX_CHUNK, 32'd0);
		put("0", 1'b1);
		repeat (62) put("0");
		put(CH_CR);
		put(CH_LF);
		repeat (60) put(other_than(CH_CR));
		put(CH_CR);
		put(CH_LF);
		put("0", 1'b1);
		repeat (63) put("0");
		commit_stage(1'b0);
		add_traffic(10, 12);
		drain();

		calm = 1'b1;
		write_reg(CFG_MAX_LINE, 32'd8);
		write_reg(CFG_SLACK, 32'd3);
		write_reg(CFG_MAX_CHUNK, 32'h20);
		add_traffic(30, 40);
		drain();
		calm = 1'b0;

		write_reg(CFG_MAX_LINE, 32'd63);
		write_reg(CFG_SLACK, 32'd255);
		write_reg(CFG_MAX_CHUNK, 32'hffff_ffff);
		put_text("0FFFFFFFF", 1'b1);
		put(CH_CR);
		put(CH_LF);
		repeat (3) put($urandom_range(0, 255));
		put_text("1g000000000", 1'b1);
		put(CH_CR);
		commit_stage(1'b0);
		add_traffic(15, 20);
		drain();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
